FILE: design/byte_pattern_replacer_assert.svh
// Assertion macros shared by the byte pattern replacer modules.
// Expects signals named clk and rst in the module that uses them.
`ifndef BYTE_PATTERN_REPLACER_ASSERT_SVH
`define BYTE_PATTERN_REPLACER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define BPR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define BPR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bpr_pkg.sv
// Package for the byte pattern replacer: sizes, register codes, result type.
// No dependencies.
package bpr_pkg;

  localparam int PAT_BYTES = 4;
  localparam int WIN_CELLS = PAT_BYTES - 1;
  localparam int PAT_W     = 32;
  localparam int OFS_W     = 32;
  localparam int TOTAL_W   = 16;
  localparam int FILL_W    = $clog2(PAT_BYTES);
  localparam int CNT_W     = $clog2(PAT_BYTES + 1);
  localparam int PIDX_W    = $clog2(PAT_BYTES);
  localparam int QDEPTH    = 2 * PAT_BYTES;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Configuration registers
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_REPLACE = 1'b1;
  localparam logic [PAT_W-1:0] SEARCH_RST  = 32'h9428_BB37;
  localparam logic [PAT_W-1:0] REPLACE_RST = 32'hD410_6835;

  typedef struct packed {
    logic               load;
    logic               shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               replaced;
    logic [OFS_W-1:0]   match_offset;
    logic               run_end;
    logic               stream_end;
    logic [TOTAL_W-1:0] replacement_count;
  } result_t;

  // Byte k of a pattern, byte 0 in the top bits
  function automatic logic [7:0] pat_byte(logic [PAT_W-1:0] pat, logic [PIDX_W-1:0] k);
    logic [PIDX_W-1:0] pos;
    pos = PIDX_W'(PAT_BYTES - 1) - k;
    return pat[8*pos +: 8];
  endfunction

endpackage

FILE: design/bpr_cell.sv
// One window cell: holds a pending byte and compares it to its search byte.
// Depends on bpr_pkg.
module bpr_cell
  import bpr_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic [7:0] in_byte,
  input  logic [7:0] right_byte,
  input  logic [7:0] pat_byte_in,
  output logic [7:0] cell_byte,
  output logic       hit
);

  logic [7:0] cell_byte_next;

  // shift takes the neighbor's byte, load takes the new stream byte
  always_comb begin
    if (ctl.shift) begin
      cell_byte_next = right_byte;
    end else if (ctl.load) begin
      cell_byte_next = in_byte;
    end else begin
      cell_byte_next = cell_byte;
    end
  end

  always_ff @(posedge clk) begin
    cell_byte <= cell_byte_next;
  end

  assign hit = (cell_byte == pat_byte_in);

endmodule

FILE: design/bpr_out_queue.sv
// Result queue: takes up to PAT_BYTES results per cycle while room is high, hands out one per cycle on pop.
// Depends on bpr_pkg and byte_pattern_replacer_assert.svh.
`include "byte_pattern_replacer_assert.svh"
module bpr_out_queue
  import bpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  push_n,
  input  result_t           push_data [PAT_BYTES],
  input  logic              pop,
  output result_t           head,
  output logic              valid,
  output logic              room
);

  result_t           slot [QDEPTH];
  result_t           slot_next [QDEPTH];
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic [QCNT_W-1:0] base;

  assign base       = count - QCNT_W'(pop);
  assign count_next = base + QCNT_W'(push_n);

  // Slots below base shift toward the head; new results land right after them
  always_comb begin
    logic [QCNT_W-1:0] rel;
    for (int j = 0; j < QDEPTH; j++) begin
      rel = QCNT_W'(j) - base;
      slot_next[j] = slot[j];
      if (QCNT_W'(j) < base) begin
        if (pop && (j < QDEPTH - 1)) begin
          slot_next[j] = slot[(j + 1) % QDEPTH];
        end
      end else if (rel < QCNT_W'(push_n)) begin
        slot_next[j] = push_data[rel[PIDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  assign head  = slot[0];
  assign valid = (count != '0);
  assign room  = (count <= QCNT_W'(QDEPTH - PAT_BYTES));

  `BPR_ASSERT_IMP(a_count_bound, 1'b1, count <= QCNT_W'(QDEPTH), "queue count above depth")
  `BPR_ASSERT_IMP(a_push_room, push_n != '0, room, "results pushed without room")
  `BPR_ASSERT_NXT(a_push_grow, (push_n != '0) && !pop,
                  count == $past(count) + QCNT_W'($past(push_n)), "queue count lost results")

endmodule

FILE: design/byte_pattern_replacer.sv
// Top level of the byte pattern replacer: config registers, window cell chain,
// step control and result queue. Depends on bpr_pkg, bpr_cell, bpr_out_queue.
//
//  port group    dir  payload
//  s_*           in   tdata[7:0] in_byte, tlast stream_last
//  m_*           out  tdata out_byte/match_offset/replacement_count, tuser, tlast stream_end
//  APB p*        cfg  0x0 search_pattern, 0x4 replace_pattern
//
// One input byte is taken per cycle while s_tready is high; its results (zero
// to four) reach m_tvalid in the next cycle and leave an eight-entry result
// queue one per cycle while m_tready is high. s_tready is low in reset and while
// more than four results wait in that queue. Reset (synchronous) empties the
// window and queue, clears offset and count, and loads the default patterns.
module byte_pattern_replacer
  import bpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tlast,
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,   // [7:0] out_byte, [39:8] match_offset,
                                       // [55:40] replacement_count
  output logic [1:0]        m_tuser,   // [0] replaced, [1] run_end
  output logic              m_tlast,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [PAT_W-1:0]   search_pattern;
  logic [PAT_W-1:0]   replace_pattern;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic [OFS_W-1:0]   byte_offset;
  logic [OFS_W-1:0]   byte_offset_next;
  logic [TOTAL_W-1:0] replace_total;
  logic [TOTAL_W-1:0] replace_total_next;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 s_accept;
  logic                 full;
  logic                 match;
  logic                 room;
  logic [CNT_W-1:0]     res_n;
  logic [CNT_W-1:0]     push_n;
  logic [OFS_W-1:0]     hit_offset;

  logic [7:0]  cell_byte [WIN_CELLS];
  logic        cell_hit  [WIN_CELLS];
  cell_ctl_t   cell_ctl  [WIN_CELLS];
  logic [7:0]  step_buf  [PAT_BYTES];
  result_t     res       [PAT_BYTES];
  result_t     head;

  // APB register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2 +: REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern  <= SEARCH_RST;
      replace_pattern <= REPLACE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SEARCH:  search_pattern  <= pwdata;
        REG_REPLACE: replace_pattern <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEARCH:  prdata = search_pattern;
      REG_REPLACE: prdata = replace_pattern;
      default:     prdata = '0;
    endcase
  end

  // Window cell chain, oldest byte in cell 0
  for (genvar k = 0; k < WIN_CELLS; k++) begin : g_cell
    logic [7:0] right;
    if (k == WIN_CELLS - 1) begin : g_tail
      assign right = s_tdata;
    end else begin : g_mid
      assign right = cell_byte[k + 1];
    end

    assign cell_ctl[k].shift = s_accept && full && !match && !s_tlast;
    assign cell_ctl[k].load  = s_accept && !full && !s_tlast && (fill == FILL_W'(k));

    bpr_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[k]),
      .in_byte     (s_tdata),
      .right_byte  (right),
      .pat_byte_in (pat_byte(search_pattern, PIDX_W'(k))),
      .cell_byte   (cell_byte[k]),
      .hit         (cell_hit[k])
    );
  end

  // Match check over the full window plus the new byte
  assign full = (fill == FILL_W'(WIN_CELLS));

  always_comb begin
    match = full && (s_tdata == pat_byte(search_pattern, PIDX_W'(PAT_BYTES - 1)));
    for (int k = 0; k < WIN_CELLS; k++) begin
      match = match && cell_hit[k];
    end
  end

  // Results of this step
  always_comb begin
    if (match) begin
      res_n = CNT_W'(PAT_BYTES);
    end else if (s_tlast) begin
      res_n = CNT_W'(fill) + CNT_W'(1);
    end else if (full) begin
      res_n = CNT_W'(1);
    end else begin
      res_n = '0;
    end
  end

  assign hit_offset = byte_offset - OFS_W'(PAT_BYTES - 1);

  always_comb begin
    if (match && (replace_total != TOTAL_MAX)) begin
      replace_total_next = replace_total + TOTAL_W'(1);
    end else begin
      replace_total_next = replace_total;
    end
  end

  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      step_buf[k] = (k < WIN_CELLS) && (FILL_W'(k) < fill) ? cell_byte[k % WIN_CELLS]
                                                             : s_tdata;
      res[k].out_byte          = match ? pat_byte(replace_pattern, PIDX_W'(k)) : step_buf[k];
      res[k].replaced          = match;
      res[k].match_offset      = match ? hit_offset : '0;
      res[k].run_end           = (CNT_W'(k) == res_n - CNT_W'(1));
      res[k].stream_end        = (CNT_W'(k) == res_n - CNT_W'(1)) && s_tlast;
      res[k].replacement_count = replace_total_next;
    end
  end

  // Step state
  always_comb begin
    if (match || s_tlast) begin
      fill_next = '0;
    end else if (full) begin
      fill_next = fill;
    end else begin
      fill_next = fill + FILL_W'(1);
    end
    byte_offset_next = s_tlast ? '0 : byte_offset + OFS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      byte_offset   <= '0;
      replace_total <= '0;
    end else if (s_accept) begin
      fill          <= fill_next;
      byte_offset   <= byte_offset_next;
      replace_total <= replace_total_next;
    end
  end

  // Handshake and result queue
  assign s_tready = room && !rst;
  assign s_accept = s_tvalid && s_tready;
  assign push_n   = s_accept ? res_n : '0;

  bpr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (res),
    .pop       (m_tvalid && m_tready),
    .head      (head),
    .valid     (m_tvalid),
    .room      (room)
  );

  assign m_tdata = {head.replacement_count, head.match_offset, head.out_byte};
  assign m_tuser = {head.run_end, head.replaced};
  assign m_tlast = head.stream_end;

endmodule
